// ----- src/v2c_pkg.sv -----
package v2c_pkg;

	localparam int VOLUME_WORDS = 4096;
	localparam int ADDR_W = $clog2(VOLUME_WORDS);

	localparam int NUM_W = 24;
	localparam int DEN_W = 12;
	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES = NUM_W / DIV_BITS;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} v2c_kind_t;

	typedef enum logic [1:0] {
		REG_CHANNELS = 2'd0,
		REG_DEPTH    = 2'd1,
		REG_HEIGHT   = 2'd2,
		REG_WIDTH    = 2'd3
	} v2c_reg_t;

	typedef struct packed {
		logic [3:0] pad_b;
		logic [3:0] pad_a;
		logic [3:0] dil;
		logic [3:0] stride;
		logic [3:0] kern;
		logic [7:0] size;
	} v2c_axis_t;

	// one division lane: work holds remaining dividend bits, quotient shifts in low
	typedef struct packed {
		logic [NUM_W-1:0] work;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
	} v2c_lane_t;

	typedef struct packed {
		logic       bad;
		logic [8:0] num;
	} v2c_geom_t;

	typedef struct packed {
		logic       pad;
		logic [7:0] pos;
	} v2c_pos_t;

	typedef struct packed {
		v2c_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       sample;
		logic              bad;
		logic [23:0]       row;
		logic [23:0]       col;
		logic [8:0]        numd;
		logic [8:0]        wout;
		logic [8:0]        hout;
		logic [3:0]        woff;
		logic [8:0]        ow;
		logic [3:0]        hoff;
		logic [8:0]        oh;
		logic [23:0]       od;
	} v2c_tag_t;

	function automatic v2c_lane_t div_steps(v2c_lane_t l);
		v2c_lane_t r;
		logic [DEN_W:0] t;
		r = l;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, r.work[NUM_W-1]};
			r.work = {r.work[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, r.den}) begin
				t = t - {1'b0, r.den};
				r.work[0] = 1'b1;
			end
			r.rem = t[DEN_W-1:0];
		end
		return r;
	endfunction

	function automatic v2c_lane_t lane_init(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
		v2c_lane_t l;
		l.work = num;
		l.rem = '0;
		l.den = den;
		return l;
	endfunction

	// padded extent minus dilated kernel; output extent is num/stride + 1
	function automatic v2c_geom_t axis_geom(v2c_axis_t a);
		v2c_geom_t g;
		logic [10:0] span;
		logic [10:0] need;
		logic [7:0] prod;
		prod = {4'b0, a.dil} * ({4'b0, a.kern} - 8'd1);
		span = {3'b0, a.size} + {7'b0, a.pad_a} + {7'b0, a.pad_b};
		need = {3'b0, prod} + 11'd1;
		g.bad = (a.kern == 4'd0) || (a.stride == 4'd0) || (span < need);
		g.num = span[8:0] - need[8:0];
		return g;
	endfunction

	function automatic v2c_pos_t axis_pos(logic [8:0] o, logic [3:0] off, v2c_axis_t a);
		v2c_pos_t r;
		logic [14:0] p;
		p = {6'b0, o} * {11'b0, a.stride} + {11'b0, off} * {11'b0, a.dil}
			- {11'b0, a.pad_a};
		r.pad = p[14] || (p >= {7'b0, a.size});
		r.pos = p[7:0];
		return r;
	endfunction

endpackage

// ----- src/v2c_ram.sv -----
module v2c_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/v2c_div.sv -----
module v2c_div import v2c_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  v2c_tag_t  in_tag,
	input  v2c_lane_t in_a,
	input  v2c_lane_t in_b,
	output logic      out_valid,
	output v2c_tag_t  out_tag,
	output v2c_lane_t out_a,
	output v2c_lane_t out_b
);

	logic      valid_s [DIV_STAGES];
	v2c_tag_t  tag_s   [DIV_STAGES];
	v2c_lane_t a_s     [DIV_STAGES];
	v2c_lane_t b_s     [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < DIV_STAGES; s++) valid_s[s] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int s = 1; s < DIV_STAGES; s++) valid_s[s] <= valid_s[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			a_s[0] <= div_steps(in_a);
			b_s[0] <= div_steps(in_b);
			for (int s = 1; s < DIV_STAGES; s++) begin
				tag_s[s] <= tag_s[s-1];
				a_s[s] <= div_steps(a_s[s-1]);
				b_s[s] <= div_steps(b_s[s-1]);
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_tag = tag_s[DIV_STAGES-1];
	assign out_a = a_s[DIV_STAGES-1];
	assign out_b = b_s[DIV_STAGES-1];

endmodule

// ----- src/volume_to_column_gather_unit.sv -----
// Throughput: one item per cycle, reads and writes alike, while the skid register is empty; four chained dividers
//   (4 quotient bits per stage) are fully pipelined and the volume RAM has a port pair.
// Writes reach the RAM at the same stage as reads, so item order is kept.
// Reset: asynchronous; clears pipeline and output valids and sets the config registers to their defaults;
//   volume RAM contents are undefined until written.
module volume_to_column_gather_unit import v2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // store_address[11:0], sample[43:12], row[67:44], column[91:68]
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // value
	output logic        m_axis_tuser,  // error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [27:0] cfg_data
);

	logic [12:0] channels_q;
	v2c_axis_t   depth_q, height_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q <= 13'd1;
			depth_q <= v2c_axis_t'(28'h0011101);
			height_q <= v2c_axis_t'(28'h0011101);
			width_q <= v2c_axis_t'(28'h0011101);
		end else if (cfg_valid) begin
			case (v2c_reg_t'(cfg_index))
				REG_CHANNELS: channels_q <= cfg_data[12:0];
				REG_DEPTH:    depth_q <= v2c_axis_t'(cfg_data);
				REG_HEIGHT:   height_q <= v2c_axis_t'(cfg_data);
				REG_WIDTH:    width_q <= v2c_axis_t'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	logic en;
	logic skid_valid_q, out_valid_q;
	assign en = !skid_valid_q;
	assign s_axis_tready = en;

	// entry stage
	logic     valid_s1;
	v2c_tag_t tag_in, tag_s1;
	logic [8:0] numw_s1, numh_s1;
	v2c_geom_t gd, gh, gw;

	always_comb begin
		gd = axis_geom(depth_q);
		gh = axis_geom(height_q);
		gw = axis_geom(width_q);
	end

	always_comb begin
		tag_in = '0;
		tag_in.kind = v2c_kind_t'(s_axis_tuser);
		tag_in.addr = s_axis_tdata[11:0];
		tag_in.sample = s_axis_tdata[43:12];
		tag_in.row = s_axis_tdata[67:44];
		tag_in.col = s_axis_tdata[91:68];
		tag_in.bad = gd.bad || gh.bad || gw.bad || (channels_q == 13'd0);
		tag_in.numd = gd.num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_in;
			numw_s1 <= gw.num;
			numh_s1 <= gh.num;
		end
	end

	// output extents of width and height
	logic      g_valid;
	v2c_tag_t  g_tag, g_tag_fix;
	v2c_lane_t g_a, g_b;

	v2c_div u_div_geom (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s1), .in_tag(tag_s1),
		.in_a(lane_init({15'b0, numw_s1}, {8'b0, width_q.stride})),
		.in_b(lane_init({15'b0, numh_s1}, {8'b0, height_q.stride})),
		.out_valid(g_valid), .out_tag(g_tag), .out_a(g_a), .out_b(g_b)
	);

	always_comb begin
		g_tag_fix = g_tag;
		g_tag_fix.wout = g_a.work[8:0] + 9'd1;
		g_tag_fix.hout = g_b.work[8:0] + 9'd1;
	end

	// row / kw, col / wout
	logic      a_valid;
	v2c_tag_t  a_tag, a_tag_fix;
	v2c_lane_t a_a, a_b;

	v2c_div u_div_first (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(g_valid), .in_tag(g_tag_fix),
		.in_a(lane_init(g_tag_fix.row, {8'b0, width_q.kern})),
		.in_b(lane_init(g_tag_fix.col, {3'b0, g_tag_fix.wout})),
		.out_valid(a_valid), .out_tag(a_tag), .out_a(a_a), .out_b(a_b)
	);

	always_comb begin
		a_tag_fix = a_tag;
		a_tag_fix.woff = a_a.rem[3:0];
		a_tag_fix.ow = a_b.rem[8:0];
	end

	// (row / kw) / kh, (col / wout) / hout
	logic      b_valid;
	v2c_tag_t  b_tag, b_tag_fix;
	v2c_lane_t b_a, b_b;

	v2c_div u_div_second (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(a_valid), .in_tag(a_tag_fix),
		.in_a(lane_init(a_a.work, {8'b0, height_q.kern})),
		.in_b(lane_init(a_b.work, {3'b0, a_tag_fix.hout})),
		.out_valid(b_valid), .out_tag(b_tag), .out_a(b_a), .out_b(b_b)
	);

	always_comb begin
		b_tag_fix = b_tag;
		b_tag_fix.hoff = b_a.rem[3:0];
		b_tag_fix.oh = b_b.rem[8:0];
		b_tag_fix.od = b_b.work;
	end

	// channel split by kd, depth output extent
	logic      c_valid;
	v2c_tag_t  c_tag;
	v2c_lane_t c_a, c_b;

	v2c_div u_div_third (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(b_valid), .in_tag(b_tag_fix),
		.in_a(lane_init(b_a.work, {8'b0, depth_q.kern})),
		.in_b(lane_init({15'b0, b_tag_fix.numd}, {8'b0, depth_q.stride})),
		.out_valid(c_valid), .out_tag(c_tag), .out_a(c_a), .out_b(c_b)
	);

	// positions and range checks
	logic [24:0] dout;
	v2c_pos_t    pz, py, px;

	always_comb begin
		dout = {1'b0, c_b.work} + 25'd1;
		pz = axis_pos(c_tag.od[8:0], c_a.rem[3:0], depth_q);
		py = axis_pos(c_tag.oh, c_tag.hoff, height_q);
		px = axis_pos(c_tag.ow, c_tag.woff, width_q);
	end

	logic              valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	v2c_kind_t         kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic [ADDR_W-1:0] waddr_s2, waddr_s3, waddr_s4, waddr_s5;
	logic [31:0]       sample_s2, sample_s3, sample_s4, sample_s5;
	logic              err_s2, err_s3, err_s4, err_s5, err_s6;
	logic              pad_s2, pad_s3, pad_s4, pad_s5;
	logic              zero_s6;
	logic [12:0]       ch_s2;
	logic [7:0]        z_s2, y_s2, y_s3, x_s2, x_s3, x_s4;
	logic [20:0]       a1_s3;
	logic [28:0]       a2_s4;
	logic [36:0]       a3_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s2 <= c_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	logic ram_we, ram_re, oob;
	logic [31:0] ram_rdata;

	assign oob = a3_s5 >= 37'(VOLUME_WORDS);
	assign ram_we = en && valid_s5 && (kind_s5 == KIND_WRITE)
		&& ({1'b0, waddr_s5} < (ADDR_W + 1)'(VOLUME_WORDS));
	assign ram_re = en;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= c_tag.kind;
			waddr_s2 <= c_tag.addr;
			sample_s2 <= c_tag.sample;
			err_s2 <= c_tag.bad || ({11'b0, channels_q} <= c_a.work)
				|| ({1'b0, c_tag.od} >= dout);
			pad_s2 <= pz.pad || py.pad || px.pad;
			ch_s2 <= c_a.work[12:0];
			z_s2 <= pz.pos;
			y_s2 <= py.pos;
			x_s2 <= px.pos;

			kind_s3 <= kind_s2;
			waddr_s3 <= waddr_s2;
			sample_s3 <= sample_s2;
			err_s3 <= err_s2;
			pad_s3 <= pad_s2;
			a1_s3 <= {8'b0, ch_s2} * {13'b0, depth_q.size} + {13'b0, z_s2};
			y_s3 <= y_s2;
			x_s3 <= x_s2;

			kind_s4 <= kind_s3;
			waddr_s4 <= waddr_s3;
			sample_s4 <= sample_s3;
			err_s4 <= err_s3;
			pad_s4 <= pad_s3;
			a2_s4 <= {8'b0, a1_s3} * {21'b0, height_q.size} + {21'b0, y_s3};
			x_s4 <= x_s3;

			kind_s5 <= kind_s4;
			waddr_s5 <= waddr_s4;
			sample_s5 <= sample_s4;
			err_s5 <= err_s4;
			pad_s5 <= pad_s4;
			a3_s5 <= {8'b0, a2_s4} * {29'b0, width_q.size} + {29'b0, x_s4};

			kind_s6 <= kind_s5;
			err_s6 <= err_s5 || (!pad_s5 && oob);
			zero_s6 <= err_s5 || pad_s5 || oob;
		end
	end

	v2c_ram #(.WIDTH(32), .DEPTH(VOLUME_WORDS)) u_volume (
		.clk(clk),
		.we(ram_we),
		.waddr(waddr_s5),
		.wdata(sample_s5),
		.re(ram_re),
		.raddr(a3_s5[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// output register with skid
	logic        inc_valid;
	logic [31:0] inc_value;
	logic [31:0] out_value_q, skid_value_q;
	logic        out_err_q, skid_err_q;

	assign inc_valid = en && valid_s6 && (kind_s6 == KIND_READ);
	assign inc_value = zero_s6 ? 32'd0 : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= skid_valid_q || inc_valid;
			skid_valid_q <= 1'b0;
		end else if (inc_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_value_q <= skid_valid_q ? skid_value_q : inc_value;
			out_err_q <= skid_valid_q ? skid_err_q : err_s6;
		end else if (inc_valid) begin
			skid_value_q <= inc_value;
			skid_err_q <= err_s6;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_value_q;
	assign m_axis_tuser = out_err_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
		else $error("flagged item carries nonzero value");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds item while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && m_axis_tready |=> !skid_valid_q)
		else $error("skid not drained after output taken");

	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !skid_valid_q)
		else $error("volume write while pipeline stalled");

endmodule
